FILE: rtl/core/dpd_pkg.sv
// shared types and constants for the dual pd position controller
// used by dpd_shrink, dpd_lane and dual_pd_position_with_soft_limits
`default_nettype none

package dpd_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int DRIVE_BITS_DEF    = 13;

  localparam int OFFSET_BITS = 13;
  localparam int GAIN_BITS   = 16;
  localparam int LIMIT_BITS  = 12;
  localparam int BOUND_BITS  = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // pipeline register stages, the last one is the output register
  localparam int STAGES = 6;

  localparam logic [GAIN_BITS-1:0]  KP_RESET        = 16'd256;
  localparam logic [GAIN_BITS-1:0]  KD_RESET        = 16'd0;
  localparam logic [LIMIT_BITS-1:0] LIM_RESET       = 12'd4095;
  localparam logic [LIMIT_BITS-1:0] DB_RESET        = 12'd0;
  localparam logic [GAIN_BITS-1:0]  WSG_RESET       = 16'd0;
  localparam logic [BOUND_BITS-1:0] SOFT_LOW_RESET  = -16'sd7500;
  localparam logic [BOUND_BITS-1:0] SOFT_HIGH_RESET = -16'sd1000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_KP        = 3'd0,
    REG_KD        = 3'd1,
    REG_LIMIT     = 3'd2,
    REG_DEAD_BAND = 3'd3,
    REG_SHRINK    = 3'd4,
    REG_SOFT_LOW  = 3'd5,
    REG_SOFT_HIGH = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0]  kp;
    logic [GAIN_BITS-1:0]  kd;
    logic [LIMIT_BITS-1:0] lim;
    logic [LIMIT_BITS-1:0] db;
    logic [GAIN_BITS-1:0]  wsg;
    logic [BOUND_BITS-1:0] soft_low;
    logic [BOUND_BITS-1:0] soft_high;
  } dpd_cfg_t;

  typedef struct packed {
    logic [STAGES-1:0] load;
  } dpd_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/dpd_shrink.sv
// window shrink term shared by both lanes: (|pa - pb| * gain) >> 8
// depends on dpd_pkg, two register stages driven by the pipeline loads
`default_nettype none

module dpd_shrink #(
  parameter int POSITION_BITS = dpd_pkg::POSITION_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire dpd_pkg::dpd_ctl_t             ctl,
  input  wire logic [dpd_pkg::GAIN_BITS-1:0] wsg,
  input  wire logic [POSITION_BITS-1:0]      pos_a,
  input  wire logic [POSITION_BITS-1:0]      pos_b,
  output logic      [POSITION_BITS+7:0]      shrink
);

  localparam int P = POSITION_BITS;

  logic [P:0]    diff;
  logic [P:0]    diff_neg;
  logic [P-1:0]  absd_nxt;
  logic [P-1:0]  absd_r;
  logic [P+15:0] prod_nxt;
  logic [P+7:0]  shrink_r;

  always_comb begin
    diff     = {pos_a[P-1], pos_a} - {pos_b[P-1], pos_b};
    diff_neg = -diff;
    absd_nxt = diff[P] ? diff_neg[P-1:0] : diff[P-1:0];
    prod_nxt = {{(P){1'b0}}, wsg} * {{(16){1'b0}}, absd_r};
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      absd_r <= absd_nxt;
    end
    if (ctl.load[1]) begin
      shrink_r <= prod_nxt[P+15:8];
    end
  end

  assign shrink = shrink_r;

endmodule

`default_nettype wire

FILE: rtl/core/dpd_lane.sv
// one pd channel: error, derivative, soft window spring, gains, limits
// depends on dpd_pkg, takes the shared shrink term from dpd_shrink
`default_nettype none

module dpd_lane #(
  parameter int POSITION_BITS = dpd_pkg::POSITION_BITS_DEF,
  parameter int DRIVE_BITS    = dpd_pkg::DRIVE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire dpd_pkg::dpd_ctl_t               ctl,
  input  wire dpd_pkg::dpd_cfg_t               cfg,
  input  wire logic [POSITION_BITS-1:0]        target,
  input  wire logic [POSITION_BITS-1:0]        position,
  input  wire logic [dpd_pkg::OFFSET_BITS-1:0] offset,
  input  wire logic [POSITION_BITS+7:0]        shrink,
  output logic      [DRIVE_BITS-1:0]           drive
);

  localparam int P    = POSITION_BITS;
  localparam int OB   = dpd_pkg::OFFSET_BITS;
  localparam int EW   = P + 1;
  localparam int DFW  = P + 2;
  localparam int PEW  = EW + 17;
  localparam int DEW  = DFW + 17;
  localparam int LW   = P + 10;
  localparam int SPW  = P + 11;
  localparam int OSW  = P + 12;
  localparam int SUMW = P + 21;
  localparam int PQW  = SUMW - 8;
  localparam int DDW  = DEW - 8;
  localparam int DRW  = P + 14;
  localparam int CAP  = (2 ** (DRIVE_BITS - 1)) - 1;
  localparam logic [15:0] CAP16 = 16'(CAP);

  // stage 0
  logic signed [EW-1:0]  e_nxt;
  logic signed [DFW-1:0] d_nxt;
  logic signed [EW-1:0]  prev_r;
  logic signed [EW-1:0]  e_r;
  logic signed [DFW-1:0] d_r;
  logic [P-1:0]          pos_r;
  logic [OB-1:0]         off_r;
  // stage 1
  logic signed [PEW-1:0] pe_nxt;
  logic signed [DEW-1:0] de_nxt;
  logic signed [PEW-1:0] pe_r;
  logic signed [DEW-1:0] de_r;
  logic [P-1:0]          pos1_r;
  logic [OB-1:0]         off1_r;
  // stage 2
  logic signed [LW-1:0]  low_v;
  logic signed [LW-1:0]  high_v;
  logic signed [LW-1:0]  pos_v;
  logic signed [SPW-1:0] spring_nxt;
  logic signed [SPW-1:0] spring_r;
  logic signed [PEW-1:0] pe2_r;
  logic signed [DEW-1:0] de2_r;
  logic [OB-1:0]         off2_r;
  // stage 3
  logic signed [OSW-1:0]  osp_v;
  logic signed [SUMW-1:0] sum_nxt;
  logic signed [DEW-1:0]  de_bias;
  logic signed [SUMW-1:0] sum_r;
  logic signed [DDW-1:0]  dd_r;
  // stage 4
  logic signed [SUMW-1:0] sum_bias;
  logic signed [PQW-1:0]  p_v;
  logic signed [DRW-1:0]  drv_nxt;
  logic signed [DRW-1:0]  drv_r;
  // limits
  logic [dpd_pkg::LIMIT_BITS-1:0] lim_v;
  logic signed [DRW-1:0]          lim_s;
  logic signed [DRW-1:0]          db_s;
  logic signed [DRW-1:0]          mag_v;
  logic signed [DRW-1:0]          sel_v;

  always_comb begin
    e_nxt = {target[P-1], target} - {position[P-1], position};
    d_nxt = {e_nxt[EW-1], e_nxt} - {prev_r[EW-1], prev_r};

    pe_nxt = $signed({{(PEW-dpd_pkg::GAIN_BITS){1'b0}}, cfg.kp})
           * $signed({{(PEW-EW){e_r[EW-1]}}, e_r});
    de_nxt = $signed({{(DEW-dpd_pkg::GAIN_BITS){1'b0}}, cfg.kd})
           * $signed({{(DEW-DFW){d_r[DFW-1]}}, d_r});

    low_v  = {{(LW-16){cfg.soft_low[15]}}, cfg.soft_low} + {2'b00, shrink};
    high_v = {{(LW-16){cfg.soft_high[15]}}, cfg.soft_high} - {2'b00, shrink};
    pos_v  = {{(LW-P){pos1_r[P-1]}}, pos1_r};
    priority if (pos_v < low_v) begin
      spring_nxt = {low_v[LW-1], low_v} - {pos_v[LW-1], pos_v};
    end else if (pos_v > high_v) begin
      spring_nxt = {high_v[LW-1], high_v} - {pos_v[LW-1], pos_v};
    end else begin
      spring_nxt = '0;
    end

    osp_v   = {{(OSW-OB){off2_r[OB-1]}}, off2_r} + {spring_r[SPW-1], spring_r};
    sum_nxt = {{(SUMW-PEW){pe2_r[PEW-1]}}, pe2_r} + {osp_v[OSW-1], osp_v, 8'h00};
    // round toward zero before the shift
    de_bias = de2_r + {{(DEW-8){1'b0}}, {8{de2_r[DEW-1]}}};

    sum_bias = sum_r + {{(SUMW-8){1'b0}}, {8{sum_r[SUMW-1]}}};
    p_v      = sum_bias[SUMW-1:8];
    drv_nxt  = {{(DRW-PQW){p_v[PQW-1]}}, p_v} + {{(DRW-DDW){dd_r[DDW-1]}}, dd_r};

    lim_v = ({4'b0000, cfg.lim} > CAP16) ? CAP16[dpd_pkg::LIMIT_BITS-1:0] : cfg.lim;
    lim_s = {{(DRW-dpd_pkg::LIMIT_BITS){1'b0}}, lim_v};
    db_s  = {{(DRW-dpd_pkg::LIMIT_BITS){1'b0}}, cfg.db};
    mag_v = drv_r[DRW-1] ? -drv_r : drv_r;
    priority if (drv_r > lim_s) begin
      sel_v = lim_s;
    end else if (drv_r < -lim_s) begin
      sel_v = -lim_s;
    end else if (mag_v < db_s) begin
      sel_v = '0;
    end else begin
      sel_v = drv_r;
    end
    drive = sel_v[DRIVE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (ctl.load[0]) begin
      prev_r <= e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      e_r   <= e_nxt;
      d_r   <= d_nxt;
      pos_r <= position;
      off_r <= offset;
    end
    if (ctl.load[1]) begin
      pe_r   <= pe_nxt;
      de_r   <= de_nxt;
      pos1_r <= pos_r;
      off1_r <= off_r;
    end
    if (ctl.load[2]) begin
      spring_r <= spring_nxt;
      pe2_r    <= pe_r;
      de2_r    <= de_r;
      off2_r   <= off1_r;
    end
    if (ctl.load[3]) begin
      sum_r <= sum_nxt;
      dd_r  <= de_bias[DEW-1:8];
    end
    if (ctl.load[4]) begin
      drv_r <= drv_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dual_pd_position_with_soft_limits.sv
// top level: config registers, pipeline valid control, two pd lanes and output merge
// depends on dpd_pkg, dpd_shrink and dpd_lane
// an accepted item passes six register stages before out_tvalid rises
// throughput: one item per cycle sustained while out_tready is high, each stage holds under back-pressure
// the output register holds a finished item while earlier stages keep filling
// reset: valid bits cleared, registers to defaults, previous errors to zero
`default_nettype none

module dual_pd_position_with_soft_limits #(
  parameter int POSITION_BITS = dpd_pkg::POSITION_BITS_DEF,
  parameter int DRIVE_BITS    = dpd_pkg::DRIVE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // target_a, target_b, position_a, position_b, stiffness_offset, zero fill
  input  wire logic [((4*POSITION_BITS+dpd_pkg::OFFSET_BITS+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // drive_a, drive_b, zero fill
  output logic [((2*DRIVE_BITS+7)/8)*8-1:0] out_tdata,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [dpd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [dpd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int P    = POSITION_BITS;
  localparam int D    = DRIVE_BITS;
  localparam int S    = dpd_pkg::STAGES;
  localparam int OB   = dpd_pkg::OFFSET_BITS;
  localparam int OUTW = ((2*D+7)/8)*8;

  dpd_pkg::dpd_cfg_t cfg_r;
  dpd_pkg::dpd_ctl_t ctl;

  logic [S-1:0] vld_r;
  logic [S-1:0] vld_nxt;
  logic [S-1:0] rdy;
  logic [S-1:0] load;

  logic [P-1:0]  target_a;
  logic [P-1:0]  target_b;
  logic [P-1:0]  position_a;
  logic [P-1:0]  position_b;
  logic [OB-1:0] stiffness_offset;
  logic [P+7:0]  shrink;
  logic [D-1:0]  drive_a;
  logic [D-1:0]  drive_b;
  logic [OUTW-1:0] out_data_r;

  assign target_a         = in_tdata[P-1:0];
  assign target_b         = in_tdata[2*P-1:P];
  assign position_a       = in_tdata[3*P-1:2*P];
  assign position_b       = in_tdata[4*P-1:3*P];
  assign stiffness_offset = in_tdata[4*P+OB-1:4*P];

  // config writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp        <= dpd_pkg::KP_RESET;
      cfg_r.kd        <= dpd_pkg::KD_RESET;
      cfg_r.lim       <= dpd_pkg::LIM_RESET;
      cfg_r.db        <= dpd_pkg::DB_RESET;
      cfg_r.wsg       <= dpd_pkg::WSG_RESET;
      cfg_r.soft_low  <= dpd_pkg::SOFT_LOW_RESET;
      cfg_r.soft_high <= dpd_pkg::SOFT_HIGH_RESET;
    end else if (cfg_valid) begin
      unique case (dpd_pkg::reg_idx_t'(cfg_index))
        dpd_pkg::REG_KP: begin
          cfg_r.kp <= cfg_data;
        end
        dpd_pkg::REG_KD: begin
          cfg_r.kd <= cfg_data;
        end
        dpd_pkg::REG_LIMIT: begin
          cfg_r.lim <= cfg_data[dpd_pkg::LIMIT_BITS-1:0];
        end
        dpd_pkg::REG_DEAD_BAND: begin
          cfg_r.db <= cfg_data[dpd_pkg::LIMIT_BITS-1:0];
        end
        dpd_pkg::REG_SHRINK: begin
          cfg_r.wsg <= cfg_data;
        end
        dpd_pkg::REG_SOFT_LOW: begin
          cfg_r.soft_low <= cfg_data;
        end
        dpd_pkg::REG_SOFT_HIGH: begin
          cfg_r.soft_high <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // per-stage valid and ready chain
  always_comb begin
    rdy[S-1] = !vld_r[S-1] || out_tready;
    for (int k = S - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    load[0]    = rdy[0] && in_tvalid;
    vld_nxt[0] = rdy[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < S; k++) begin
      load[k]    = rdy[k] && vld_r[k-1];
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
    ctl.load = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = rdy[0];

  dpd_shrink #(
    .POSITION_BITS(P)
  ) u_shrink (
    .clk    (clk),
    .ctl    (ctl),
    .wsg    (cfg_r.wsg),
    .pos_a  (position_a),
    .pos_b  (position_b),
    .shrink (shrink)
  );

  dpd_lane #(
    .POSITION_BITS(P),
    .DRIVE_BITS   (D)
  ) u_lane_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .cfg      (cfg_r),
    .target   (target_a),
    .position (position_a),
    .offset   (stiffness_offset),
    .shrink   (shrink),
    .drive    (drive_a)
  );

  dpd_lane #(
    .POSITION_BITS(P),
    .DRIVE_BITS   (D)
  ) u_lane_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .cfg      (cfg_r),
    .target   (target_b),
    .position (position_b),
    .offset   (stiffness_offset),
    .shrink   (shrink),
    .drive    (drive_b)
  );

  // merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (load[S-1]) begin
      out_data_r <= {{(OUTW-2*D){1'b0}}, drive_b, drive_a};
    end
  end

  assign out_tvalid = vld_r[S-1];
  assign out_tdata  = out_data_r;

  a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item did not enter the first stage");

  a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r) && !out_tready |-> !in_tready)
    else $error("input taken while every stage is full and output stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0)
    else $error("valid bits not cleared by reset");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S-2] && !load[S-1] |=> vld_r[S-2])
    else $error("item dropped between last two stages");

endmodule

`default_nettype wire

FILE: bench/tb_dual_pd_position_with_soft_limits.sv
// testbench for dual_pd_position_with_soft_limits: directed and random stream items
// under several register settings, checked against an in-bench drive predictor
// depends on dpd_pkg and the dual_pd_position_with_soft_limits rtl

module tb_dual_pd_position_with_soft_limits;
  import dpd_pkg::*;

  localparam int POS_W = POSITION_BITS_DEF;
  localparam int DRIVE_W = DRIVE_BITS_DEF;
  localparam int IN_W = ((4*POS_W+OFFSET_BITS+7)/8)*8;
  localparam int OUT_W = ((2*DRIVE_W+7)/8)*8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 165;
  localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic signed [DRIVE_W-1:0] a;
    logic signed [DRIVE_W-1:0] b;
  } drive_pair_t;

  class drive_checker;
    logic [GAIN_BITS-1:0] kp, kd, wsg;
    logic [LIMIT_BITS-1:0] lim, db;
    logic signed [BOUND_BITS-1:0] soft_lo, soft_hi;
    longint prev_err[2];
    drive_pair_t pending_drives[$];
    int mismatches;

    function new();
      kp = KP_RESET;
      kd = KD_RESET;
      lim = LIM_RESET;
      db = DB_RESET;
      wsg = WSG_RESET;
      soft_lo = SOFT_LOW_RESET;
      soft_hi = SOFT_HIGH_RESET;
      prev_err[0] = 0;
      prev_err[1] = 0;
      mismatches = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] v);
      case (idx)
        REG_KP: kp = v;
        REG_KD: kd = v;
        REG_LIMIT: lim = v[LIMIT_BITS-1:0];
        REG_DEAD_BAND: db = v[LIMIT_BITS-1:0];
        REG_SHRINK: wsg = v;
        REG_SOFT_LOW: soft_lo = v;
        REG_SOFT_HIGH: soft_hi = v;
        default: ;
      endcase
    endfunction

    function logic signed [DRIVE_W-1:0] lane(int ch, longint tgt, longint pos, longint off,
                                             longint shrink);
      longint e, d, lo, hi, spring, p, dd, drv, lim_l, cap, kp_l, kd_l;
      kp_l = longint'(kp);
      kd_l = longint'(kd);
      lim_l = longint'(lim);
      e = tgt - pos;
      d = e - prev_err[ch];
      prev_err[ch] = e;
      lo = longint'(soft_lo) + shrink;
      hi = longint'(soft_hi) - shrink;
      spring = 0;
      // low bound wins when the window is crossed
      if (pos < lo) begin
        spring = lo - pos;
      end else if (pos > hi) begin
        spring = hi - pos;
      end
      p = (kp_l * e + 256 * (off + spring)) / 256;
      dd = (kd_l * d) / 256;
      drv = p + dd;
      cap = (longint'(1) << (DRIVE_W-1)) - 1;
      if (lim_l > cap) begin
        lim_l = cap;
      end
      if (drv > lim_l) begin
        drv = lim_l;
      end else if (drv < -lim_l) begin
        drv = -lim_l;
      end else if ((drv < 0 ? -drv : drv) < longint'(db)) begin
        drv = 0;
      end
      return drv[DRIVE_W-1:0];
    endfunction

    function void predict_drives(logic [IN_W-1:0] item);
      longint ta, tb, pa, pb, off, pos_gap, shrink, wsg_l;
      drive_pair_t exp_pair;
      ta = longint'($signed(item[POS_W-1:0]));
      tb = longint'($signed(item[2*POS_W-1:POS_W]));
      pa = longint'($signed(item[3*POS_W-1:2*POS_W]));
      pb = longint'($signed(item[4*POS_W-1:3*POS_W]));
      off = longint'($signed(item[4*POS_W+OFFSET_BITS-1:4*POS_W]));
      wsg_l = longint'(wsg);
      pos_gap = pa - pb;
      if (pos_gap < 0) begin
        pos_gap = -pos_gap;
      end
      shrink = (pos_gap * wsg_l) >> 8;
      exp_pair.a = lane(0, ta, pa, off, shrink);
      exp_pair.b = lane(1, tb, pb, off, shrink);
      pending_drives.push_back(exp_pair);
    endfunction

    function void check_drives(logic [OUT_W-1:0] item);
      drive_pair_t exp_pair;
      logic signed [DRIVE_W-1:0] got_a, got_b;
      got_a = item[DRIVE_W-1:0];
      got_b = item[2*DRIVE_W-1:DRIVE_W];
      if (pending_drives.size() == 0) begin
        $display("%0t unexpected item: drive_a %0d drive_b %0d", $time, got_a, got_b);
        mismatches++;
        return;
      end
      exp_pair = pending_drives.pop_front();
      if (got_a !== exp_pair.a) begin
        $display("%0t drive_a mismatch: expected %0d, got %0d", $time, exp_pair.a, got_a);
        mismatches++;
      end
      if (got_b !== exp_pair.b) begin
        $display("%0t drive_b mismatch: expected %0d, got %0d", $time, exp_pair.b, got_b);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  drive_checker sb;
  int cycles = 0;
  int tx_pct = 0;
  int rx_pct = 0;
  int stall_left = 0;
  int lo_i = -7500;
  int hi_i = -1000;

  dual_pd_position_with_soft_limits uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_len();
    if ($urandom_range(0, 9) == 0) begin
      return int'($urandom_range(20, 60));
    end
    return int'($urandom_range(1, 3));
  endfunction

  function automatic logic [POS_W-1:0] clip_pos(int v);
    if (v > 32767) begin
      return 16'sd32767;
    end
    if (v < -32768) begin
      return -16'sd32768;
    end
    return v[POS_W-1:0];
  endfunction

  function automatic logic [IN_W-1:0] pack_item(logic [POS_W-1:0] ta, logic [POS_W-1:0] tb,
                                                logic [POS_W-1:0] pa, logic [POS_W-1:0] pb,
                                                logic [OFFSET_BITS-1:0] off);
    logic [IN_W-1:0] item;
    item = '0;
    item[4*POS_W+OFFSET_BITS-1:0] = {off, pb, pa, tb, ta};
    return item;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("dual_pd_position_with_soft_limits test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.apply_reg(cfg_index, cfg_data);
      end
      if (in_tvalid && in_tready) begin
        sb.predict_drives(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        sb.check_drives(out_tdata);
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_pct > 0 && $urandom_range(0, 99) < rx_pct) begin
      out_tready <= 1'b0;
      stall_left <= pick_len() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_item(input logic [IN_W-1:0] item);
    int gap;
    gap = 0;
    if (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
      gap = pick_len();
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= item;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (STAGES + 2) @(negedge clk);
  endtask

  task automatic program_regs(input logic [GAIN_BITS-1:0] kp_v, input logic [GAIN_BITS-1:0] kd_v,
                              input logic [LIMIT_BITS-1:0] lim_v,
                              input logic [LIMIT_BITS-1:0] db_v,
                              input logic [GAIN_BITS-1:0] wsg_v,
                              input int lo_v, input int hi_v);
    drain();
    cfg_write(REG_KP, kp_v);
    cfg_write(REG_KD, kd_v);
    cfg_write(REG_LIMIT, {4'd0, lim_v});
    cfg_write(REG_DEAD_BAND, {4'd0, db_v});
    cfg_write(REG_SHRINK, wsg_v);
    cfg_write(REG_SOFT_LOW, lo_v[BOUND_BITS-1:0]);
    cfg_write(REG_SOFT_HIGH, hi_v[BOUND_BITS-1:0]);
    if ($urandom_range(0, 2) == 0) begin
      cfg_write(REG_NONE, 16'($urandom));
    end
    cfg_valid <= 1'b0;
    lo_i = int'($signed(lo_v[BOUND_BITS-1:0]));
    hi_i = int'($signed(hi_v[BOUND_BITS-1:0]));
  endtask

  task automatic random_phase(input int ph);
    int kind, pa, pb, span;
    logic [GAIN_BITS-1:0] kp_v, kd_v, wsg_v;
    logic [LIMIT_BITS-1:0] lim_v, db_v;
    int lo_v, hi_v;
    kp_v = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 768));
    kd_v = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1024));
    lim_v = 12'(($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(0, 4095));
    db_v = 12'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 64));
    wsg_v = 16'(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 128));
    lo_v = int'($urandom_range(0, 40000)) - 30000;
    hi_v = lo_v + int'($urandom_range(0, 20000));
    if (hi_v > 32767) begin
      hi_v = 32767;
    end
    if ($urandom_range(0, 4) == 0) begin
      lo_v = int'($urandom_range(0, 65535)) - 32768;
      hi_v = int'($urandom_range(0, 65535)) - 32768;
    end
    if (ph == RANDOM_PHASES - 2) begin
      kp_v = 16'hffff;
      kd_v = 16'hffff;
      wsg_v = 16'hffff;
      lim_v = 12'd4095;
      db_v = 12'd4095;
      lo_v = -32768;
      hi_v = 32767;
    end
    if (ph == RANDOM_PHASES - 1) begin
      kp_v = 16'd0;
      kd_v = 16'd0;
      wsg_v = 16'd0;
      lim_v = 12'd0;
      db_v = 12'd0;
      lo_v = 32767;
      hi_v = -32768;
    end
    program_regs(kp_v, kd_v, lim_v, db_v, wsg_v, lo_v, hi_v);
    tx_pct = (ph % 3 == 0) ? 0 : 25;
    rx_pct = (ph % 3 == 0) ? 0 : 25;
    span = (hi_i > lo_i ? hi_i - lo_i : 0) + 2000;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      kind = int'($urandom_range(0, 9));
      if (kind < 3) begin
        send_item(pack_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            13'($urandom)));
      end else begin
        // plausible motion near the window with small tracking errors
        pa = lo_i - 1000 + int'($urandom_range(0, span));
        pb = pa + int'($urandom_range(0, 400)) - 200;
        send_item(pack_item(clip_pos(pa + int'($urandom_range(0, 600)) - 300),
                            clip_pos(pb + int'($urandom_range(0, 600)) - 300),
                            clip_pos(pa), clip_pos(pb),
                            13'(int'($urandom_range(0, 400)) - 200)));
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_KP;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: unit gain, window -7500 .. -1000
    tx_pct = 20;
    rx_pct = 20;
    send_item(pack_item(16'sd0, 16'sd0, 16'sd0, 16'sd0, 13'sd0));
    send_item(pack_item(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 13'sd4095));
    send_item(pack_item(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, -13'sd4096));
    send_item(pack_item(-16'sd4000, -16'sd4000, -16'sd4000, -16'sd4000, 13'sd0));
    send_item(pack_item(-16'sd4000, -16'sd4000, -16'sd7600, -16'sd900, 13'sd0));
    send_item(pack_item(-16'sd4010, -16'sd3990, -16'sd4000, -16'sd4000, 13'sd100));
    send_item(pack_item(-16'sd1000, -16'sd7500, -16'sd1000, -16'sd7500, -13'sd1));
    send_item(pack_item(-16'sd4000, -16'sd4000, -16'sd4000, -16'sd4000, 13'sd4095));

    // full scale gains with a crossed window
    program_regs(16'hffff, 16'hffff, 12'd4095, 12'd4095, 16'hffff, 32767, -32768);
    send_item(pack_item(16'sd0, 16'sd0, 16'sd0, 16'sd0, 13'sd0));
    send_item(pack_item(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 13'sd0));
    send_item(pack_item(16'sd1, -16'sd1, 16'sd0, 16'sd0, 13'sd0));
    send_item(pack_item(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -13'sd4096));
    send_item(pack_item(16'sd100, -16'sd100, 16'sd32767, -16'sd32768, 13'sd0));

    // everything zero, drives pinned at zero
    program_regs(16'd0, 16'd0, 12'd0, 12'd0, 16'd0, -32768, 32767);
    drain();
    cfg_write(REG_NONE, 16'hffff);
    cfg_valid <= 1'b0;
    send_item(pack_item(16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 13'sd4095));
    send_item(pack_item(16'sd0, 16'sd0, 16'sd0, 16'sd0, -13'sd4096));

    // dead band wider than the limit
    program_regs(16'd256, 16'd128, 12'd100, 12'd500, 16'd256, -200, 200);
    send_item(pack_item(16'sd50, -16'sd50, 16'sd0, 16'sd0, 13'sd0));
    send_item(pack_item(16'sd300, -16'sd300, 16'sd0, 16'sd0, 13'sd0));
    send_item(pack_item(16'sd0, 16'sd0, 16'sd150, -16'sd150, 13'sd0));
    send_item(pack_item(-16'sd20, 16'sd20, 16'sd0, 16'sd0, 13'sd40));
    send_item(pack_item(16'sd0, 16'sd0, 16'sd0, 16'sd0, 13'sd0));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_phase(ph);
    end

    drain();
    repeat (2 * STAGES + 4) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("dual_pd_position_with_soft_limits test passed");
    end else begin
      $display("dual_pd_position_with_soft_limits test failed");
    end
    $finish;
  end

endmodule
